>>> src/dbj_pkg.sv
`default_nettype none

package dbj_pkg;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned DIST_W   = 12;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned JOG_W    = 3;
    localparam int unsigned AXIS_W   = 2;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE_X = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE_Y = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODE     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

    // Latched axis codes
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;

    // Robot modes
    localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ENABLED  = 4'd5;

    // Jog codes
    localparam logic [JOG_W-1:0] JOG_STOP     = 3'd0;
    localparam logic [JOG_W-1:0] JOG_X_MINUS  = 3'd1;
    localparam logic [JOG_W-1:0] JOG_X_PLUS   = 3'd2;
    localparam logic [JOG_W-1:0] JOG_J1_PLUS  = 3'd3;
    localparam logic [JOG_W-1:0] JOG_J1_MINUS = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd3;

    // Configuration reset values
    localparam logic [DIST_W-1:0] FAR_LIMIT_RST = 12'd200;
    localparam logic [DIST_W-1:0] BAND_LOW_RST  = 12'd80;
    localparam logic [DIST_W-1:0] BAND_HIGH_RST = 12'd120;
    localparam logic [CNT_W-1:0]  HOLDOFF_RST   = 16'd2000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DIST_W-1:0] distance_mm;
        logic [MODE_W-1:0] mode_code;
    } item_t;

    typedef struct packed {
        logic             request_enable;
        logic             request_disable;
        logic             jog_valid;
        logic [JOG_W-1:0] jog_code;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0] far_limit_mm;
        logic [DIST_W-1:0] band_low_mm;
        logic [DIST_W-1:0] band_high_mm;
        logic [CNT_W-1:0]  holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic [AXIS_W-1:0] latched_axis;
        logic [JOG_W-1:0]  last_jog;
        logic [MODE_W-1:0] current_mode;
        logic [CNT_W-1:0]  since_enable;
        logic [CNT_W-1:0]  since_disable;
    } state_t;

endpackage

`default_nettype wire

>>> src/dbj_if.sv
`default_nettype none

interface dbj_item_if;
    logic                      valid;
    logic                      ready;
    logic [dbj_pkg::CMD_W-1:0]  command;
    logic [dbj_pkg::DIST_W-1:0] distance_mm;
    logic [dbj_pkg::MODE_W-1:0] mode_code;

    modport source (output valid, command, distance_mm, mode_code, input ready);
    modport sink   (input valid, command, distance_mm, mode_code, output ready);
endinterface

interface dbj_result_if;
    logic                     valid;
    logic                     ready;
    logic                     request_enable;
    logic                     request_disable;
    logic                     jog_valid;
    logic [dbj_pkg::JOG_W-1:0] jog_code;

    modport source (output valid, request_enable, request_disable, jog_valid, jog_code,
                    input ready);
    modport sink   (input valid, request_enable, request_disable, jog_valid, jog_code,
                    output ready);
endinterface

`default_nettype wire

>>> src/dbj_decide.sv
`default_nettype none

module dbj_decide (
    input  wire dbj_pkg::item_t   item,
    input  wire dbj_pkg::cfg_t    cfg,
    input  wire dbj_pkg::state_t  state,
    output dbj_pkg::state_t       state_next,
    output dbj_pkg::result_t      res
);

    logic [dbj_pkg::AXIS_W-1:0] axis;
    logic                       axis_match;
    logic                       is_far;
    logic                       below_band;
    logic                       above_band;
    logic                       in_band;
    logic                       jog_req;
    logic [dbj_pkg::JOG_W-1:0]  jog_want;

    assign axis       = (item.command == dbj_pkg::CMD_SAMPLE_X) ? dbj_pkg::AXIS_X
                                                               : dbj_pkg::AXIS_Y;
    assign axis_match = (state.latched_axis == dbj_pkg::AXIS_NONE)
                        || (state.latched_axis == axis);
    assign is_far     = item.distance_mm > cfg.far_limit_mm;
    assign below_band = item.distance_mm < cfg.band_low_mm;
    assign above_band = item.distance_mm > cfg.band_high_mm;
    assign in_band    = !below_band && !above_band;

    always_comb
    begin
        state_next = state;
        res        = '0;
        jog_req    = 1'b0;
        jog_want   = dbj_pkg::JOG_STOP;

        unique case (item.command)
            dbj_pkg::CMD_TICK:
            begin
                // saturate both holdoff counters
                if (state.since_enable != '1)
                begin
                    state_next.since_enable = state.since_enable + 1'b1;
                end
                if (state.since_disable != '1)
                begin
                    state_next.since_disable = state.since_disable + 1'b1;
                end
            end
            dbj_pkg::CMD_MODE:
            begin
                state_next.current_mode = item.mode_code;
            end
            dbj_pkg::CMD_SAMPLE_X, dbj_pkg::CMD_SAMPLE_Y:
            begin
                if (axis_match)
                begin
                    priority if (is_far)
                    begin
                        jog_req = 1'b1;
                        if (state.current_mode == dbj_pkg::MODE_ENABLED
                            && state.since_disable > cfg.holdoff_ticks)
                        begin
                            res.request_disable      = 1'b1;
                            state_next.since_disable = '0;
                            state_next.latched_axis  = dbj_pkg::AXIS_NONE;
                        end
                    end
                    else if (in_band)
                    begin
                        jog_req = 1'b1;
                        if (state.current_mode == dbj_pkg::MODE_DISABLED
                            && state.since_enable > cfg.holdoff_ticks)
                        begin
                            res.request_enable      = 1'b1;
                            state_next.since_enable = '0;
                            state_next.latched_axis = axis;
                        end
                    end
                    else if (state.current_mode == dbj_pkg::MODE_ENABLED
                             && state.latched_axis == axis)
                    begin
                        // inverted band edges: below low wins
                        jog_req = 1'b1;
                        if (below_band)
                        begin
                            jog_want = (axis == dbj_pkg::AXIS_X) ? dbj_pkg::JOG_X_MINUS
                                                                 : dbj_pkg::JOG_J1_PLUS;
                        end
                        else
                        begin
                            jog_want = (axis == dbj_pkg::AXIS_X) ? dbj_pkg::JOG_X_PLUS
                                                                 : dbj_pkg::JOG_J1_MINUS;
                        end
                    end
                    else
                    begin
                        jog_req = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase

        // drop a jog request that repeats the last one
        if (jog_req && jog_want != state.last_jog)
        begin
            res.jog_valid       = 1'b1;
            res.jog_code        = jog_want;
            state_next.last_jog = jog_want;
        end
    end

endmodule

`default_nettype wire

>>> src/distance_band_jog_controller.sv
// Distance band jog controller.
//
// Channels: "item" carries one beat per event (distance sample for axis x or y,
// robot mode update, or millisecond tick). "result" returns exactly one beat for
// every item beat, in order, holding the enable/disable requests and an optional
// jog request. Both use valid/ready; a beat moves when both are high.
// Configuration: cfg_write/cfg_index/cfg_data write one of four registers
// (far limit, band low, band high, holdoff); write only while the block holds no
// item in flight.
// Path: each item passes the input register, then the result register, before
// its result is offered on the result channel. Throughput: one beat per cycle,
// sustained while the receiver keeps ready high, since the whole decision is a
// few compares and two counter increments between the two registers.
// Stall: when the receiver holds ready low, the result register holds its beat and
// the input register takes one more item; after that item.ready falls until the
// result beat moves.
// Reset: clears the pipeline, the latched axis, last jog, mode and both holdoff
// counters, and loads the configuration registers with their default values.
`default_nettype none

module distance_band_jog_controller (
    input  wire                              clk,
    input  wire                              rst_n,
    dbj_item_if.sink                         item,
    dbj_result_if.source                     result,
    input  wire                              cfg_write,
    input  wire [dbj_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [dbj_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Input stage
    logic              s1_valid_reg;
    dbj_pkg::item_t    s1_item_reg;

    // Result stage
    logic              out_valid_reg;
    dbj_pkg::result_t  out_res_reg;

    // Controller state and configuration
    dbj_pkg::state_t   state_reg;
    dbj_pkg::state_t   state_next;
    dbj_pkg::cfg_t     cfg_reg;
    dbj_pkg::result_t  res_next;

    logic              advance;
    logic              take_item;

    // Advance the held item when the result register is free or being emptied.
    assign advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take_item = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take_item)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            s1_item_reg.command     <= item.command;
            s1_item_reg.distance_mm <= item.distance_mm;
            s1_item_reg.mode_code   <= item.mode_code;
        end
    end

    dbj_decide u_decide (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Commit state only when the item's result is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.latched_axis  <= dbj_pkg::AXIS_NONE;
            state_reg.last_jog      <= dbj_pkg::JOG_STOP;
            state_reg.current_mode  <= dbj_pkg::MODE_UNKNOWN;
            state_reg.since_enable  <= '0;
            state_reg.since_disable <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.request_enable  = out_res_reg.request_enable;
    assign result.request_disable = out_res_reg.request_disable;
    assign result.jog_valid       = out_res_reg.jog_valid;
    assign result.jog_code        = out_res_reg.jog_code;

    // Configuration registers: truncate write data to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.far_limit_mm  <= dbj_pkg::FAR_LIMIT_RST;
            cfg_reg.band_low_mm   <= dbj_pkg::BAND_LOW_RST;
            cfg_reg.band_high_mm  <= dbj_pkg::BAND_HIGH_RST;
            cfg_reg.holdoff_ticks <= dbj_pkg::HOLDOFF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dbj_pkg::REG_FAR_LIMIT:
                    cfg_reg.far_limit_mm  <= cfg_data[dbj_pkg::DIST_W-1:0];
                dbj_pkg::REG_BAND_LOW:
                    cfg_reg.band_low_mm   <= cfg_data[dbj_pkg::DIST_W-1:0];
                dbj_pkg::REG_BAND_HIGH:
                    cfg_reg.band_high_mm  <= cfg_data[dbj_pkg::DIST_W-1:0];
                dbj_pkg::REG_HOLDOFF:
                    cfg_reg.holdoff_ticks <= cfg_data[dbj_pkg::CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/dbj_checker.sv
`default_nettype none

module dbj_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        out_valid,
    input wire                        out_ready,
    input wire                        request_enable,
    input wire                        request_disable,
    input wire                        jog_valid,
    input wire [dbj_pkg::JOG_W-1:0]   jog_code
);

    // Hold a stalled beat unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(request_enable)
            && $stable(request_disable) && $stable(jog_valid) && $stable(jog_code)))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(request_enable && request_disable))
        else $error("enable and disable requested in one beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !jog_valid) |-> (jog_code == dbj_pkg::JOG_STOP))
        else $error("jog code set without jog request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && jog_valid) |-> (jog_code == dbj_pkg::JOG_STOP
            || jog_code == dbj_pkg::JOG_X_MINUS || jog_code == dbj_pkg::JOG_X_PLUS
            || jog_code == dbj_pkg::JOG_J1_PLUS || jog_code == dbj_pkg::JOG_J1_MINUS))
        else $error("jog code out of range");

endmodule

bind distance_band_jog_controller dbj_checker u_dbj_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .request_enable  (result.request_enable),
    .request_disable (result.request_disable),
    .jog_valid       (result.jog_valid),
    .jog_code        (result.jog_code)
);

`default_nettype wire
